/* hw/rtl/cdms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdms_pkg: shared types, codes and digit helpers
// Item and result layouts, display mode codes, default tick intervals and
// the constant-divisor decimal conversions used by the frame builder.
// ----------------------------------------------------------------------------
package cdms_pkg;

  localparam int unsigned BOOT_TICKS_DEF   = 2;
  localparam int unsigned NORMAL_TICKS_DEF = 10;
  localparam int unsigned FLASH_TICKS_DEF  = 30;
  localparam int unsigned BLINK_TICKS_DEF  = 5;

  localparam logic [3:0]  NIB_BLANK   = 4'hF;
  localparam logic [15:0] FRAME_BLANK = 16'hFFFF;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MODE = 1'b1;

  typedef enum logic [2:0] {
    DM_BOOT   = 3'd0,
    DM_TIME   = 3'd1,
    DM_FLASH  = 3'd2,
    DM_VOLUME = 3'd3,
    DM_EDIT   = 3'd4
  } mode_t;

  typedef struct packed {
    logic               op;
    logic [2:0]         new_mode;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic signed [5:0]  alarm_hour;
    logic signed [6:0]  alarm_minute;
    logic [4:0]         edit_hour;
    logic [5:0]         edit_minute;
    logic [13:0]        flash_number;
    logic [4:0]         volume_level;
    logic [2:0]         status_flags;
  } in_item_t;

  // indicators: [7] snooze [6] nap [5] wifi [4] alarm set [3] alarm colon
  //             [2] main colon [1] pm [0] am
  typedef struct packed {
    logic [15:0] main_digits;
    logic [15:0] alarm_digits;
    logic [7:0]  indicators;
    logic        boot_advance;
  } out_item_t;

  // Two decimal digits {tens, ones} of a value below 128 (tens kept to 4 bits).
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [15:0] p;
    logic [6:0]  t;
    logic [6:0]  o;
    p = 16'(v) * 16'd205;
    t = 7'(p >> 11);
    o = v - 7'(t * 7'd10);
    return {t[3:0], o[3:0]};
  endfunction

  // Four digits, right-aligned, leading positions blank.
  function automatic logic [15:0] flash_digits(input logic [13:0] v);
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [13:0] q1;
    logic [7:0]  q2;
    logic [4:0]  q3;
    logic [3:0]  d0;
    logic [3:0]  d1;
    logic [3:0]  d2;
    logic [3:0]  d3;
    p1 = 32'(v) * 32'd52429;
    p2 = 32'(v) * 32'd5243;
    p3 = 32'(v) * 32'd8389;
    q1 = 14'(p1 >> 19);
    q2 = 8'(p2 >> 19);
    q3 = 5'(p3 >> 23);
    d0 = 4'(v - 14'(q1 * 14'd10));
    d1 = 4'(q1 - 14'({6'd0, q2} * 14'd10));
    d2 = 4'(q2 - 8'({3'd0, q3} * 8'd10));
    d3 = (q3 >= 5'd10) ? 4'(q3 - 5'd10) : q3[3:0];
    return {(q3 != 5'd0) ? d3 : NIB_BLANK,
            (q2 != 8'd0) ? d2 : NIB_BLANK,
            (q1 != 14'd0) ? d1 : NIB_BLANK,
            d0};
  endfunction

endpackage

/* hw/rtl/cdms_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdms_if: valid/ready channels of the display sequencer
// Input channel carries one tick or mode-write transaction; output channel
// carries one display frame.
// ----------------------------------------------------------------------------
interface cdms_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [2:0]         new_mode;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic signed [5:0]  alarm_hour;
  logic signed [6:0]  alarm_minute;
  logic [4:0]         edit_hour;
  logic [5:0]         edit_minute;
  logic [13:0]        flash_number;
  logic [4:0]         volume_level;
  logic [2:0]         status_flags;

  modport source (
    output valid, op, new_mode, hour, minute, alarm_hour, alarm_minute,
           edit_hour, edit_minute, flash_number, volume_level, status_flags,
    input  ready
  );
  modport sink (
    input  valid, op, new_mode, hour, minute, alarm_hour, alarm_minute,
           edit_hour, edit_minute, flash_number, volume_level, status_flags,
    output ready
  );
endinterface

interface cdms_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] main_digits;
  logic [15:0] alarm_digits;
  logic [7:0]  indicators;
  logic        boot_advance;

  modport source (
    output valid, main_digits, alarm_digits, indicators, boot_advance,
    input  ready
  );
  modport sink (
    input  valid, main_digits, alarm_digits, indicators, boot_advance,
    output ready
  );
endinterface

/* hw/rtl/cdms_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdms_in_stage: input register
// Captures one transaction; refills in the same cycle it hands one on.
// ----------------------------------------------------------------------------
module cdms_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  cdms_in_if.sink           in_bus,
  input  logic              take,
  output cdms_pkg::in_item_t item,
  output logic              item_valid
);
  import cdms_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     accept;

  assign in_bus.ready = !valid_r || take;
  assign accept       = in_bus.valid && in_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{op:           in_bus.op,
                  new_mode:     in_bus.new_mode,
                  hour:         in_bus.hour,
                  minute:       in_bus.minute,
                  alarm_hour:   in_bus.alarm_hour,
                  alarm_minute: in_bus.alarm_minute,
                  edit_hour:    in_bus.edit_hour,
                  edit_minute:  in_bus.edit_minute,
                  flash_number: in_bus.flash_number,
                  volume_level: in_bus.volume_level,
                  status_flags: in_bus.status_flags};
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

/* hw/rtl/cdms_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdms_engine: mode state and frame builder
// Holds mode, tick and blink counters and the current frame, and works out
// the next state and the result frame of one transaction in a single pass.
// ----------------------------------------------------------------------------
module cdms_engine #(
  parameter int unsigned BOOT_TICKS   = cdms_pkg::BOOT_TICKS_DEF,
  parameter int unsigned NORMAL_TICKS = cdms_pkg::NORMAL_TICKS_DEF,
  parameter int unsigned FLASH_TICKS  = cdms_pkg::FLASH_TICKS_DEF,
  parameter int unsigned BLINK_TICKS  = cdms_pkg::BLINK_TICKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  cdms_pkg::in_item_t item,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output cdms_pkg::out_item_t res,
  output logic               res_valid
);
  import cdms_pkg::*;

  mode_t       mode_r,   mode_nxt;
  logic [4:0]  tick_r,   tick_nxt;
  logic        colon_r,  colon_nxt;
  logic [2:0]  blink_r,  blink_nxt;
  logic        mark_r,   mark_nxt;
  logic [15:0] main_r,   main_nxt;
  logic [15:0] alarm_r,  alarm_nxt;
  logic [7:0]  ind_r,    ind_nxt;
  logic        mil_r;

  logic [4:0]  limit;
  logic [4:0]  tick_inc;
  logic        tick_hit;
  logic        mode_ok;
  logic        boot_adv;
  logic [2:0]  blink_inc;
  logic        blink_wrap;
  logic [4:0]  hr_disp;
  logic [7:0]  hr_bcd;
  logic [7:0]  mn_bcd;
  logic [7:0]  ah_bcd;
  logic [7:0]  am_bcd;
  logic [7:0]  eh_bcd;
  logic [7:0]  em_bcd;
  logic [7:0]  vol_bcd;
  logic        no_alarm;
  logic [15:0] normal_main;
  logic [15:0] normal_alarm;
  logic [7:0]  normal_ind;
  logic [7:0]  enter_ind;
  logic [15:0] flash_main;
  logic [15:0] vol_main;

  always_comb begin
    unique case (mode_r)
      DM_BOOT:             limit = 5'(BOOT_TICKS);
      DM_TIME:             limit = 5'(NORMAL_TICKS);
      DM_FLASH, DM_VOLUME: limit = 5'(FLASH_TICKS);
      default:             limit = 5'd1;
    endcase
  end

  assign tick_inc   = tick_r + 5'd1;
  assign tick_hit   = tick_inc >= limit;
  assign mode_ok    = item.new_mode <= DM_EDIT;
  assign blink_inc  = blink_r + 3'd1;
  assign blink_wrap = blink_inc >= 3'(BLINK_TICKS);

  // 12-hour display unless mil_r is set: hour 0 reads 12, hours above 12 drop by 12
  always_comb begin
    if (mil_r) begin
      hr_disp = item.hour;
    end else if (item.hour > 5'd12) begin
      hr_disp = item.hour - 5'd12;
    end else if (item.hour == 5'd0) begin
      hr_disp = 5'd12;
    end else begin
      hr_disp = item.hour;
    end
  end

  assign hr_bcd  = bcd2({2'd0, hr_disp});
  assign mn_bcd  = bcd2({1'b0, item.minute});
  assign ah_bcd  = bcd2({2'd0, item.alarm_hour[4:0]});
  assign am_bcd  = bcd2({1'b0, item.alarm_minute[5:0]});
  assign eh_bcd  = bcd2({2'd0, item.edit_hour});
  assign em_bcd  = bcd2({1'b0, item.edit_minute});
  assign vol_bcd = bcd2({2'd0, item.volume_level});

  assign no_alarm     = item.alarm_hour[5] || item.alarm_minute[6];
  assign normal_main  = {((hr_disp > 5'd9) || mil_r) ? hr_bcd[7:4] : NIB_BLANK,
                         hr_bcd[3:0], mn_bcd};
  assign normal_alarm = no_alarm ? FRAME_BLANK : {ah_bcd, am_bcd};
  assign normal_ind   = {ind_r[7:6], item.status_flags[0], !no_alarm, !no_alarm,
                         colon_r, !mil_r && (item.hour >= 5'd12),
                         !mil_r && (item.hour < 5'd12)};
  assign enter_ind    = {item.status_flags[2], item.status_flags[1], 6'd0};
  assign flash_main   = flash_digits(item.flash_number);
  assign vol_main     = {8'hFF, (vol_bcd[7:4] == 4'd0) ? NIB_BLANK : vol_bcd[7:4],
                         vol_bcd[3:0]};

  always_comb begin
    mode_nxt  = mode_r;
    tick_nxt  = tick_r;
    colon_nxt = colon_r;
    blink_nxt = blink_r;
    mark_nxt  = mark_r;
    main_nxt  = main_r;
    alarm_nxt = alarm_r;
    ind_nxt   = ind_r;
    res_valid = 1'b0;
    boot_adv  = 1'b0;
    if (take) begin
      unique case (item.op)
        OP_MODE: begin
          if (mode_ok) begin
            res_valid = 1'b1;
            mode_nxt  = mode_t'(item.new_mode);
            tick_nxt  = 5'd0;
            alarm_nxt = FRAME_BLANK;
            ind_nxt   = enter_ind;
            if (item.new_mode == DM_FLASH) begin
              main_nxt = flash_main;
            end else if (item.new_mode == DM_VOLUME) begin
              main_nxt = vol_main;
            end else begin
              main_nxt = FRAME_BLANK;
            end
          end
        end
        default: begin
          tick_nxt = tick_inc;
          if (tick_hit) begin
            tick_nxt  = 5'd0;
            res_valid = 1'b1;
            unique case (mode_r)
              DM_BOOT: begin
                boot_adv = 1'b1;
              end
              DM_TIME: begin
                main_nxt  = normal_main;
                alarm_nxt = normal_alarm;
                ind_nxt   = normal_ind;
                colon_nxt = !colon_r;
              end
              DM_FLASH, DM_VOLUME: begin
                // timeout: same as a mode write of normal
                mode_nxt  = DM_TIME;
                main_nxt  = FRAME_BLANK;
                alarm_nxt = FRAME_BLANK;
                ind_nxt   = enter_ind;
              end
              default: begin
                blink_nxt = blink_wrap ? 3'd0 : blink_inc;
                mark_nxt  = mark_r ^ blink_wrap;
                alarm_nxt = {eh_bcd, em_bcd};
                ind_nxt   = {ind_r[7:5], mark_r ^ blink_wrap, 1'b1, ind_r[2:0]};
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= DM_BOOT;
      tick_r  <= 5'd0;
      colon_r <= 1'b0;
      blink_r <= 3'd0;
      mark_r  <= 1'b0;
      main_r  <= FRAME_BLANK;
      alarm_r <= FRAME_BLANK;
      ind_r   <= 8'd0;
      mil_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      tick_r  <= tick_nxt;
      colon_r <= colon_nxt;
      blink_r <= blink_nxt;
      mark_r  <= mark_nxt;
      main_r  <= main_nxt;
      alarm_r <= alarm_nxt;
      ind_r   <= ind_nxt;
      if (cfg_we) begin
        mil_r <= cfg_wdata;
      end
    end
  end

  assign res = '{main_digits:  main_nxt,
                 alarm_digits: alarm_nxt,
                 indicators:   ind_nxt,
                 boot_advance: boot_adv};

endmodule

/* hw/rtl/cdms_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdms_out_stage: result register
// Holds one frame until the sink takes it; free when empty or draining.
// ----------------------------------------------------------------------------
module cdms_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  cdms_pkg::out_item_t res,
  cdms_out_if.source          out_bus,
  output logic                free
);
  import cdms_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t res_r;

  assign free = !valid_r || out_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_bus.valid        = valid_r;
  assign out_bus.main_digits  = res_r.main_digits;
  assign out_bus.alarm_digits = res_r.alarm_digits;
  assign out_bus.indicators   = res_r.indicators;
  assign out_bus.boot_advance = res_r.boot_advance;

endmodule

/* hw/rtl/clock_display_mode_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_display_mode_sequencer: clock display mode and frame controller
// An accepted transaction waits in the input register; its frame is then
// held in the result register.
// Throughput: one transaction per cycle while the output sink keeps up.
// Reset (synchronous, rst_n low): boot mode, counters cleared, frames blank,
// 12-hour display.
// ----------------------------------------------------------------------------
module clock_display_mode_sequencer #(
  parameter int unsigned BOOT_TICKS   = cdms_pkg::BOOT_TICKS_DEF,
  parameter int unsigned NORMAL_TICKS = cdms_pkg::NORMAL_TICKS_DEF,
  parameter int unsigned FLASH_TICKS  = cdms_pkg::FLASH_TICKS_DEF,
  parameter int unsigned BLINK_TICKS  = cdms_pkg::BLINK_TICKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cdms_in_if.sink     in_bus,
  cdms_out_if.source  out_bus,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import cdms_pkg::*;

  in_item_t  item;
  logic      item_valid;
  out_item_t res;
  logic      res_valid;
  logic      out_free;
  logic      take;

  // item moves on only when the result slot can take whatever it makes
  assign take = item_valid && out_free;

  cdms_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .take       (take),
    .item       (item),
    .item_valid (item_valid)
  );

  cdms_engine #(
    .BOOT_TICKS   (BOOT_TICKS),
    .NORMAL_TICKS (NORMAL_TICKS),
    .FLASH_TICKS  (FLASH_TICKS),
    .BLINK_TICKS  (BLINK_TICKS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res),
    .res_valid (res_valid)
  );

  cdms_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (res_valid),
    .res     (res),
    .out_bus (out_bus),
    .free    (out_free)
  );

endmodule

/* hw/rtl/cdms_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdms_checker: port-level checks for the display sequencer
// Watches handshakes and frame indicators on the top level ports.
// ----------------------------------------------------------------------------
module cdms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] main_digits,
  input logic [15:0] alarm_digits,
  input logic [7:0]  indicators,
  input logic        boot_advance
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({main_digits, alarm_digits, indicators, boot_advance}))
    else $error("stalled frame changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("frame valid right after reset");

  // a new frame needs a transaction through both registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("frame without a transaction two cycles earlier");

  a_alarm_set_colon: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && indicators[4] |-> indicators[3])
    else $error("alarm mark lit without alarm colon");

  a_am_pm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(indicators[0] && indicators[1]))
    else $error("am and pm both lit");

endmodule

bind clock_display_mode_sequencer cdms_checker u_cdms_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .main_digits  (out_bus.main_digits),
  .alarm_digits (out_bus.alarm_digits),
  .indicators   (out_bus.indicators),
  .boot_advance (out_bus.boot_advance)
);

/* dv/clock_display_mode_sequencer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_display_mode_sequencer_test: self-checking bench for the display sequencer
// Drives tick and mode-write transactions with random gaps and output stalls,
// tracks the mode, counters and frames in a scoreboard, and checks every frame.
// ----------------------------------------------------------------------------
module clock_display_mode_sequencer_test;
  import cdms_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_ITEMS = 220;
  localparam int unsigned SETTLE_CYCLES = 4;

  localparam int IND_AM     = 0;
  localparam int IND_PM     = 1;
  localparam int IND_MCOLON = 2;
  localparam int IND_ACOLON = 3;
  localparam int IND_ASET   = 4;
  localparam int IND_WIFI   = 5;
  localparam int IND_NAP    = 6;
  localparam int IND_SNOOZE = 7;

  localparam int FLAG_WIFI  = 0;
  localparam int FLAG_NAP   = 1;
  localparam int FLAG_SLEEP = 2;

  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

  // Tracks the display state and holds the frames still owed by the block.
  class frame_tracker;
    bit        h24;
    mode_t     mode;
    bit [4:0]  ticks;
    bit        colon;
    bit [2:0]  blink;
    bit        mark;
    bit [15:0] main_f;
    bit [15:0] alarm_f;
    bit [7:0]  ind;
    out_item_t frames_due[$];
    int        errors;

    function new();
      h24 = 0;
      mode = DM_BOOT;
      ticks = 0;
      colon = 0;
      blink = 0;
      mark = 0;
      main_f = FRAME_BLANK;
      alarm_f = FRAME_BLANK;
      ind = '0;
      errors = 0;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    function bit [15:0] two_pairs(int unsigned a, int unsigned b);
      return {4'(a / 10), 4'(a % 10), 4'(b / 10), 4'(b % 10)};
    endfunction

    // low decimal digits from position 3 down to 'lowest', leading blanks
    function bit [15:0] right_aligned(int unsigned v, int lowest);
      bit [15:0] f;
      f = FRAME_BLANK;
      for (int p = 3; p >= lowest; p--) begin
        f[(3 - p) * 4 +: 4] = 4'(v % 10);
        v = v / 10;
        if (v == 0) break;
      end
      return f;
    endfunction

    function void enter(mode_t m, in_item_t it);
      mode = m;
      ticks = 0;
      main_f = FRAME_BLANK;
      alarm_f = FRAME_BLANK;
      ind = '0;
      ind[IND_NAP] = it.status_flags[FLAG_NAP];
      ind[IND_SNOOZE] = it.status_flags[FLAG_SLEEP];
      if (m == DM_FLASH) main_f = right_aligned(it.flash_number, 0);
      else if (m == DM_VOLUME) main_f = right_aligned(it.volume_level, 2);
    endfunction

    function void draw_time(in_item_t it);
      int unsigned h;
      h = it.hour;
      ind[IND_AM] = !h24 && h < 12;
      ind[IND_PM] = !h24 && h >= 12;
      if (!h24) begin
        if (h > 12) h = h - 12;
        else if (h == 0) h = 12;
      end
      main_f = two_pairs(h, it.minute);
      if (!h24 && h <= 9) main_f[15:12] = NIB_BLANK;
      ind[IND_MCOLON] = colon;
      colon = ~colon;
      // any negative alarm field means no alarm pending
      if (it.alarm_hour[5] || it.alarm_minute[6]) begin
        alarm_f = FRAME_BLANK;
        ind[IND_ACOLON] = 1'b0;
        ind[IND_ASET] = 1'b0;
      end else begin
        alarm_f = two_pairs(6'(it.alarm_hour), 7'(it.alarm_minute));
        ind[IND_ACOLON] = 1'b1;
        ind[IND_ASET] = 1'b1;
      end
      ind[IND_WIFI] = it.status_flags[FLAG_WIFI];
    endfunction

    function void draw_edit(in_item_t it);
      blink = blink + 1;
      if (blink >= BLINK_TICKS_DEF) begin
        blink = 0;
        mark = ~mark;
      end
      alarm_f = two_pairs(it.edit_hour, it.edit_minute);
      ind[IND_ACOLON] = 1'b1;
      ind[IND_ASET] = mark;
    endfunction

    function void note_input(in_item_t it);
      int unsigned lim;
      bit          step_boot;
      out_item_t   r;
      step_boot = 0;
      if (it.op == OP_MODE) begin
        if (it.new_mode > DM_EDIT) return;
        enter(mode_t'(it.new_mode), it);
      end else begin
        case (mode)
          DM_BOOT: lim = BOOT_TICKS_DEF;
          DM_TIME: lim = NORMAL_TICKS_DEF;
          DM_FLASH, DM_VOLUME: lim = FLASH_TICKS_DEF;
          default: lim = 1;
        endcase
        ticks = ticks + 1;
        if (ticks < lim) return;
        ticks = 0;
        case (mode)
          DM_BOOT: step_boot = 1;
          DM_TIME: draw_time(it);
          DM_FLASH, DM_VOLUME: enter(DM_TIME, it);
          default: draw_edit(it);
        endcase
      end
      r.main_digits = main_f;
      r.alarm_digits = alarm_f;
      r.indicators = ind;
      r.boot_advance = step_boot;
      frames_due.push_back(r);
    endfunction

    function void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %h, got %h", $time, what, want, got);
      end
    endfunction

    function void check_frame(out_item_t got);
      out_item_t want;
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: frame expected none, got %h", $time, got);
        return;
      end
      want = frames_due.pop_front();
      check_field("main_digits", want.main_digits, got.main_digits);
      check_field("alarm_digits", want.alarm_digits, got.alarm_digits);
      check_field("indicators", want.indicators, got.indicators);
      check_field("boot_advance", want.boot_advance, got.boot_advance);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   gap_pct;
  int   stall_pct;
  int unsigned cycles = 0;

  cdms_in_if  in_ch ();
  cdms_out_if out_ch ();

  frame_tracker sb = new;

  clock_display_mode_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input({in_ch.op, in_ch.new_mode, in_ch.hour, in_ch.minute,
                     in_ch.alarm_hour, in_ch.alarm_minute, in_ch.edit_hour,
                     in_ch.edit_minute, in_ch.flash_number, in_ch.volume_level,
                     in_ch.status_flags});
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_frame({out_ch.main_digits, out_ch.alarm_digits, out_ch.indicators,
                      out_ch.boot_advance});
  end

  function automatic in_item_t random_item();
    in_item_t it;
    int       sel;
    it.op = 1'($urandom);
    it.new_mode = 3'($urandom);
    it.hour = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
    it.minute = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
    sel = $urandom_range(0, 9);
    it.alarm_hour = (sel < 2) ? '1 : (sel == 2) ? 6'($urandom) : 6'($urandom_range(0, 23));
    sel = $urandom_range(0, 9);
    it.alarm_minute = (sel < 2) ? '1 : (sel == 2) ? 7'($urandom) : 7'($urandom_range(0, 59));
    it.edit_hour = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
    it.edit_minute = ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                                 : 6'($urandom_range(0, 59));
    sel = $urandom_range(0, 9);
    it.flash_number = (sel == 0) ? 14'($urandom) :
                      (sel == 1) ? 14'($urandom_range(0, 9)) : 14'($urandom_range(0, 9999));
    it.volume_level = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 30));
    it.status_flags = 3'($urandom);
    return it;
  endfunction

  // valid stays high across back-to-back transactions; lowered only for a gap
  task automatic send_item(in_item_t it);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    {in_ch.op, in_ch.new_mode, in_ch.hour, in_ch.minute, in_ch.alarm_hour,
     in_ch.alarm_minute, in_ch.edit_hour, in_ch.edit_minute, in_ch.flash_number,
     in_ch.volume_level, in_ch.status_flags} <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_tick();
    in_item_t it;
    it = random_item();
    it.op = OP_TICK;
    send_item(it);
  endtask

  task automatic send_mode(logic [2:0] m);
    in_item_t it;
    it = random_item();
    it.op = OP_MODE;
    it.new_mode = m;
    send_item(it);
  endtask

  // ticks may leave the block busy with no frame owed, hence the extra cycles
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_format(bit v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.h24 = v;
  endtask

  initial begin
    in_item_t it;
    int       sent;
    int       run;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    in_ch.valid <= 1'b0;
    {in_ch.op, in_ch.new_mode, in_ch.hour, in_ch.minute, in_ch.alarm_hour,
     in_ch.alarm_minute, in_ch.edit_hour, in_ch.edit_minute, in_ch.flash_number,
     in_ch.volume_level, in_ch.status_flags} <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_format(1'b0);

    // directed: boot step, midnight with no alarm, number display limits,
    // unknown modes, alarm edit through one blink period
    send_tick();
    send_tick();
    it = random_item();
    it.op = OP_MODE;
    it.new_mode = DM_TIME;
    it.status_flags = 3'b110;
    send_item(it);
    repeat (NORMAL_TICKS_DEF - 1) send_tick();
    it = random_item();
    it.op = OP_TICK;
    it.hour = 5'd0;
    it.minute = 6'd0;
    it.alarm_hour = '1;
    it.alarm_minute = '1;
    it.status_flags = 3'b001;
    send_item(it);
    it = random_item();
    it.op = OP_MODE;
    it.new_mode = DM_FLASH;
    it.flash_number = 14'd9999;
    send_item(it);
    it.flash_number = 14'd0;
    send_item(it);
    it.flash_number = '1;
    send_item(it);
    it.new_mode = DM_VOLUME;
    it.volume_level = 5'd30;
    send_item(it);
    it.volume_level = 5'd0;
    send_item(it);
    send_mode(MODE_UNUSED_LAST);
    send_mode(MODE_UNUSED_FIRST);
    send_mode(DM_EDIT);
    it = random_item();
    it.op = OP_TICK;
    it.edit_hour = 5'd23;
    it.edit_minute = 6'd59;
    send_item(it);
    it.edit_hour = 5'd0;
    it.edit_minute = 6'd0;
    send_item(it);
    repeat (BLINK_TICKS_DEF - 2) send_tick();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  write_format(1'b1); end
        1: begin gap_pct = 75; stall_pct = 0;  write_format(1'b0); end
        2: begin gap_pct = 0;  stall_pct = 75; write_format(1'b1); end
        default: begin gap_pct = 10; stall_pct = 10; write_format(1'($urandom)); end
      endcase
      sent = 0;
      // each burst is a mode write followed by a run of ticks
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 15) == 0) begin
          send_mode(3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)));
        end else begin
          send_mode(3'($urandom_range(DM_BOOT, DM_EDIT)));
          sent++;
        end
        run = $urandom_range(0, 40);
        repeat (run) begin
          send_tick();
          sent++;
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cdms_pkg.sv
hw/rtl/cdms_if.sv
hw/rtl/cdms_in_stage.sv
hw/rtl/cdms_engine.sv
hw/rtl/cdms_out_stage.sv
hw/rtl/clock_display_mode_sequencer.sv
hw/rtl/cdms_checker.sv
dv/clock_display_mode_sequencer_test.sv
